// ===== design/tps_pkg.sv =====
// Package for the triangle point snap block: payload structs, arithmetic widths,
// register indexes and pipeline lengths. It depends on nothing else.
package tps_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SIDE_W  = PROD_W + 1;
    localparam int LEN_W   = PROD_W;
    localparam int DOT_W   = PROD_W + 1;
    localparam int Q_W     = DIFF_W;
    localparam int MAG_W   = LEN_W + Q_W;
    localparam int TGT_W   = Q_W + 2;
    localparam int DIST_W  = PROD_W;
    localparam int CFG_IDX_W = 3;

    localparam int EDGE_LAT = 3 + Q_W + 3;
    localparam int DLY_N    = EDGE_LAT - 2;
    localparam int VLD_N    = EDGE_LAT + 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SIDE_W-1:0]  side_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [TGT_W-1:0]   tgt_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [Q_W-1:0]    quo_t;
    typedef logic [DIFF_W-1:0] absd_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
    } point_t;

    typedef struct packed {
        coord_t snapped_x;
        coord_t snapped_y;
    } result_t;

    typedef struct packed {
        logic   ok;
        coord_t x;
        coord_t y;
        dist_t  d;
    } cand_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } cfg_idx_t;

    function automatic cand_t pick(input cand_t a, input cand_t b);
        pick = a;
        if (b.ok && (!a.ok || (b.d < a.d))) begin
            pick = b;
        end
    endfunction

endpackage

// ===== design/tps_edge.sv =====
// One triangle edge: projection, parameter range check, pipelined rounding
// divider and squared distance of the projected point. Uses tps_pkg.
module tps_edge (
    input  logic            aclk,
    input  logic            en,
    input  tps_pkg::point_t p,
    input  tps_pkg::coord_t ux,
    input  tps_pkg::coord_t uy,
    input  tps_pkg::coord_t vx,
    input  tps_pkg::coord_t vy,
    output tps_pkg::cand_t  cand
);

    typedef struct packed {
        logic            ok;
        logic            negx;
        logic            negy;
        tps_pkg::len_t   len2;
        tps_pkg::mag_t   remx;
        tps_pkg::mag_t   remy;
        tps_pkg::quo_t   qx;
        tps_pkg::quo_t   qy;
        tps_pkg::point_t p;
    } div_t;

    tps_pkg::prod_t  exx_reg, eyy_reg, wxe_reg, wye_reg;
    tps_pkg::diff_t  ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    tps_pkg::point_t p1_reg, p2_reg, p4_reg, p5_reg;
    tps_pkg::len_t   len2_reg;
    tps_pkg::dot_t   dot_reg;
    logic            ok2_reg, ok4_reg, ok5_reg;
    div_t            div_reg [0:tps_pkg::Q_W];
    tps_pkg::coord_t tx_reg, ty_reg;
    tps_pkg::prod_t  sqx_reg, sqy_reg;
    tps_pkg::cand_t  cand_reg;

    tps_pkg::diff_t  ex, ey, wx, wy;
    tps_pkg::len_t   len2;
    tps_pkg::dot_t   dot;
    tps_pkg::absd_t  absx, absy;
    tps_pkg::quo_t   qx_r, qy_r;
    tps_pkg::tgt_t   offx, offy;
    tps_pkg::diff_t  dx, dy;

    always_comb begin
        ex   = tps_pkg::diff_t'(vx) - tps_pkg::diff_t'(ux);
        ey   = tps_pkg::diff_t'(vy) - tps_pkg::diff_t'(uy);
        wx   = tps_pkg::diff_t'(p.point_x) - tps_pkg::diff_t'(ux);
        wy   = tps_pkg::diff_t'(p.point_y) - tps_pkg::diff_t'(uy);
        len2 = tps_pkg::len_t'(exx_reg) + tps_pkg::len_t'(eyy_reg);
        dot  = tps_pkg::dot_t'(wxe_reg) + tps_pkg::dot_t'(wye_reg);
        absx = ex2_reg[tps_pkg::DIFF_W-1] ? tps_pkg::absd_t'(-ex2_reg)
                                          : tps_pkg::absd_t'(ex2_reg);
        absy = ey2_reg[tps_pkg::DIFF_W-1] ? tps_pkg::absd_t'(-ey2_reg)
                                          : tps_pkg::absd_t'(ey2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            exx_reg <= tps_pkg::prod_t'(ex) * tps_pkg::prod_t'(ex);
            eyy_reg <= tps_pkg::prod_t'(ey) * tps_pkg::prod_t'(ey);
            wxe_reg <= tps_pkg::prod_t'(wx) * tps_pkg::prod_t'(ex);
            wye_reg <= tps_pkg::prod_t'(wy) * tps_pkg::prod_t'(ey);
            ex1_reg <= ex;
            ey1_reg <= ey;
            p1_reg  <= p;

            len2_reg <= len2;
            dot_reg  <= dot;
            ok2_reg  <= (len2 != '0) && !dot[tps_pkg::DOT_W-1]
                        && (tps_pkg::len_t'(dot) <= len2);
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
            p2_reg   <= p1_reg;

            div_reg[0].ok   <= ok2_reg;
            div_reg[0].negx <= ex2_reg[tps_pkg::DIFF_W-1];
            div_reg[0].negy <= ey2_reg[tps_pkg::DIFF_W-1];
            div_reg[0].len2 <= len2_reg;
            div_reg[0].remx <= tps_pkg::mag_t'(tps_pkg::len_t'(dot_reg))
                               * tps_pkg::mag_t'(absx);
            div_reg[0].remy <= tps_pkg::mag_t'(tps_pkg::len_t'(dot_reg))
                               * tps_pkg::mag_t'(absy);
            div_reg[0].qx   <= '0;
            div_reg[0].qy   <= '0;
            div_reg[0].p    <= p2_reg;
        end
    end

    for (genvar i = 0; i < tps_pkg::Q_W; i++) begin : g_div
        localparam int K = tps_pkg::Q_W - 1 - i;
        tps_pkg::mag_t dsh;
        div_t          nxt;

        always_comb begin
            dsh = tps_pkg::mag_t'(div_reg[i].len2) << K;
            nxt = div_reg[i];
            if (div_reg[i].remx >= dsh) begin
                nxt.remx  = div_reg[i].remx - dsh;
                nxt.qx[K] = 1'b1;
            end
            if (div_reg[i].remy >= dsh) begin
                nxt.remy  = div_reg[i].remy - dsh;
                nxt.qy[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[i+1] <= nxt;
            end
        end
    end

    always_comb begin
        qx_r = div_reg[tps_pkg::Q_W].qx;
        qy_r = div_reg[tps_pkg::Q_W].qy;
        if ((div_reg[tps_pkg::Q_W].remx << 1)
                >= tps_pkg::mag_t'(div_reg[tps_pkg::Q_W].len2)) begin
            qx_r = qx_r + tps_pkg::quo_t'(1);
        end
        if ((div_reg[tps_pkg::Q_W].remy << 1)
                >= tps_pkg::mag_t'(div_reg[tps_pkg::Q_W].len2)) begin
            qy_r = qy_r + tps_pkg::quo_t'(1);
        end
        offx = div_reg[tps_pkg::Q_W].negx ? -tps_pkg::tgt_t'({1'b0, qx_r})
                                          :  tps_pkg::tgt_t'({1'b0, qx_r});
        offy = div_reg[tps_pkg::Q_W].negy ? -tps_pkg::tgt_t'({1'b0, qy_r})
                                          :  tps_pkg::tgt_t'({1'b0, qy_r});
        dx = tps_pkg::diff_t'(tx_reg) - tps_pkg::diff_t'(p4_reg.point_x);
        dy = tps_pkg::diff_t'(ty_reg) - tps_pkg::diff_t'(p4_reg.point_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg  <= tps_pkg::coord_t'(tps_pkg::tgt_t'(ux) + offx);
            ty_reg  <= tps_pkg::coord_t'(tps_pkg::tgt_t'(uy) + offy);
            ok4_reg <= div_reg[tps_pkg::Q_W].ok;
            p4_reg  <= div_reg[tps_pkg::Q_W].p;

            sqx_reg <= tps_pkg::prod_t'(dx) * tps_pkg::prod_t'(dx);
            sqy_reg <= tps_pkg::prod_t'(dy) * tps_pkg::prod_t'(dy);
            ok5_reg <= ok4_reg;
            p5_reg  <= '{point_x: tx_reg, point_y: ty_reg};

            cand_reg.ok <= ok5_reg;
            cand_reg.x  <= p5_reg.point_x;
            cand_reg.y  <= p5_reg.point_y;
            cand_reg.d  <= tps_pkg::dist_t'(sqx_reg) + tps_pkg::dist_t'(sqy_reg);
        end
    end

    assign cand = cand_reg;

endmodule

// ===== design/triangle_point_snap.sv =====
// Top level of the triangle point snap block: vertex registers, inside test,
// vertex candidates, an edge unit for each triangle edge and the final selection. Uses tps_pkg, tps_edge.
//
//  channel  direction  handshake                payload
//  s_       in         s_valid / s_ready        s_data   (point_x, point_y)
//  m_       out        m_valid / m_ready        m_data   (snapped_x, snapped_y)
//  cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item enters per clock while the output is not stalled; m_valid for an item rises once it has
// passed the whole pipeline, whose depth includes the 17 quotient stages of the edge dividers.
// Reset clears the valid bits and the vertex registers to zero.
// A stalled output freezes the whole pipeline, and s_ready falls in the same cycle.
module triangle_point_snap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tps_pkg::point_t                   s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tps_pkg::result_t                  m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  tps_pkg::coord_t                   cfg_data
);

    typedef struct packed {
        logic            in_tri;
        tps_pkg::point_t p;
        tps_pkg::cand_t  best;
    } carry_t;

    logic            en;
    logic            vld_reg [0:tps_pkg::VLD_N-1];
    tps_pkg::coord_t vx_reg [0:2];
    tps_pkg::coord_t vy_reg [0:2];
    tps_pkg::point_t in_reg, t1_p_reg, t2_p_reg, sel_p_reg;
    tps_pkg::prod_t  sp1_reg [0:2];
    tps_pkg::prod_t  sp2_reg [0:2];
    tps_pkg::prod_t  sqx_reg [0:2];
    tps_pkg::prod_t  sqy_reg [0:2];
    tps_pkg::side_t  s_reg [0:2];
    tps_pkg::dist_t  vd_reg [0:2];
    carry_t          dly_reg [0:tps_pkg::DLY_N-1];
    tps_pkg::cand_t  edge_cand [0:2];
    tps_pkg::cand_t  l_reg, r_reg;
    logic            sel_in_reg;
    tps_pkg::result_t out_reg;

    carry_t          t3;
    tps_pkg::cand_t  vc;
    tps_pkg::cand_t  win;
    logic            neg, pos;

    assign en        = !vld_reg[tps_pkg::VLD_N-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[tps_pkg::VLD_N-1];
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (tps_pkg::cfg_idx_t'(cfg_index))
                tps_pkg::REG_A_X: vx_reg[0] <= cfg_data;
                tps_pkg::REG_A_Y: vy_reg[0] <= cfg_data;
                tps_pkg::REG_B_X: vx_reg[1] <= cfg_data;
                tps_pkg::REG_B_Y: vy_reg[1] <= cfg_data;
                tps_pkg::REG_C_X: vx_reg[2] <= cfg_data;
                tps_pkg::REG_C_Y: vy_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tps_pkg::VLD_N; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < tps_pkg::VLD_N; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_tri
        localparam int J = (i + 1) % 3;
        tps_pkg::diff_t pvx, pvy, uvx, uvy, dpx, dpy;

        always_comb begin
            pvx = tps_pkg::diff_t'(in_reg.point_x) - tps_pkg::diff_t'(vx_reg[J]);
            pvy = tps_pkg::diff_t'(in_reg.point_y) - tps_pkg::diff_t'(vy_reg[J]);
            uvx = tps_pkg::diff_t'(vx_reg[i]) - tps_pkg::diff_t'(vx_reg[J]);
            uvy = tps_pkg::diff_t'(vy_reg[i]) - tps_pkg::diff_t'(vy_reg[J]);
            dpx = tps_pkg::diff_t'(vx_reg[i]) - tps_pkg::diff_t'(in_reg.point_x);
            dpy = tps_pkg::diff_t'(vy_reg[i]) - tps_pkg::diff_t'(in_reg.point_y);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sp1_reg[i] <= tps_pkg::prod_t'(pvx) * tps_pkg::prod_t'(uvy);
                sp2_reg[i] <= tps_pkg::prod_t'(uvx) * tps_pkg::prod_t'(pvy);
                sqx_reg[i] <= tps_pkg::prod_t'(dpx) * tps_pkg::prod_t'(dpx);
                sqy_reg[i] <= tps_pkg::prod_t'(dpy) * tps_pkg::prod_t'(dpy);
                s_reg[i]   <= tps_pkg::side_t'(sp1_reg[i]) - tps_pkg::side_t'(sp2_reg[i]);
                vd_reg[i]  <= tps_pkg::dist_t'(sqx_reg[i]) + tps_pkg::dist_t'(sqy_reg[i]);
            end
        end

        tps_edge u_edge (
            .aclk (aclk),
            .en   (en),
            .p    (in_reg),
            .ux   (vx_reg[i]),
            .uy   (vy_reg[i]),
            .vx   (vx_reg[J]),
            .vy   (vy_reg[J]),
            .cand (edge_cand[i])
        );
    end

    always_comb begin
        neg = 1'b0;
        pos = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (s_reg[i][tps_pkg::SIDE_W-1]) begin
                neg = 1'b1;
            end else if (s_reg[i] != '0) begin
                pos = 1'b1;
            end
        end
        t3.in_tri = !(neg && pos);
        t3.p      = t2_p_reg;
        t3.best   = '{ok: 1'b1, x: vx_reg[0], y: vy_reg[0], d: vd_reg[0]};
        for (int i = 1; i < 3; i++) begin
            vc        = '{ok: 1'b1, x: vx_reg[i], y: vy_reg[i], d: vd_reg[i]};
            t3.best   = tps_pkg::pick(t3.best, vc);
        end
        win = tps_pkg::pick(l_reg, r_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg   <= s_data;
            t1_p_reg <= in_reg;
            t2_p_reg <= t1_p_reg;
            dly_reg[0] <= t3;
            for (int i = 1; i < tps_pkg::DLY_N; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
            l_reg      <= tps_pkg::pick(dly_reg[tps_pkg::DLY_N-1].best, edge_cand[0]);
            r_reg      <= tps_pkg::pick(edge_cand[1], edge_cand[2]);
            sel_p_reg  <= dly_reg[tps_pkg::DLY_N-1].p;
            sel_in_reg <= dly_reg[tps_pkg::DLY_N-1].in_tri;
            if (sel_in_reg) begin
                out_reg <= '{snapped_x: sel_p_reg.point_x, snapped_y: sel_p_reg.point_y};
            end else begin
                out_reg <= '{snapped_x: win.x, snapped_y: win.y};
            end
        end
    end

endmodule

// ===== design/tps_check.sv =====
// Port checker for the triangle point snap block and its bind to the top level.
// Uses tps_pkg for the result type.
module tps_check (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input tps_pkg::result_t m_data,
    input logic             cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result item changed while stalled.");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow the output stall.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result item present after reset.");

    a_cfg_ready: assert property (@(posedge aclk)
        cfg_ready)
        else $error("Configuration port not ready.");

endmodule

bind triangle_point_snap tps_check u_tps_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
